// ----- hdl/hhdt_pkg.sv -----
// Shared constants, types and helpers for the heavy hitter table.
`default_nettype none
package hhdt_pkg;

    localparam int NE   = 64;
    localparam int IW   = $clog2(NE);
    localparam int CW   = IW + 1;
    localparam int KW   = 64;
    localparam int CNTW = 48;
    localparam int AW   = 31;
    localparam int PW   = 41;
    localparam int ICW  = 7;
    localparam int CFGW = 41;
    localparam int QB   = 6;

    localparam logic [CNTW-1:0] CNT_MAX = {CNTW{1'b1}};

    localparam logic [1:0] FN_UPDATE = 2'd0;
    localparam logic [1:0] FN_QUERY  = 2'd1;
    localparam logic [1:0] FN_REPORT = 2'd2;
    localparam logic [1:0] FN_CLEAR  = 2'd3;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_PERIOD = 2'd1;
    localparam logic [1:0] CFG_ICAP   = 2'd2;

    localparam logic [ICW-1:0] ICAP_RST   = 7'd16;
    localparam logic [PW-1:0]  PERIOD_RST = 41'd1024;

    typedef struct packed {
        logic            vld;
        logic [KW-1:0]   key;
        logic [CNTW-1:0] cnt;
    } entry_t;

    typedef struct packed {
        logic [1:0]      func;
        logic [KW-1:0]   key;
        logic [AW-1:0]   amount;
        logic [CNTW-1:0] threshold;
    } in_t;

    typedef struct packed {
        logic [KW-1:0]   key_out;
        logic            hit;
        logic [CNTW-1:0] low_estimate;
        logic [CNTW-1:0] high_estimate;
        logic [CNTW-1:0] peak_estimate;
        logic            capacity_saturated;
        logic            last_item;
    } out_t;

    typedef struct packed {
        logic shift;
        logic clr;
    } ring_ctl_t;

    function automatic logic [CNTW-1:0] sat_add(input logic [CNTW-1:0] a,
                                                input logic [CNTW-1:0] b);
        logic [CNTW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNTW] ? CNT_MAX : s[CNTW-1:0];
    endfunction

    function automatic logic [CW-1:0] cap_lim(input logic [ICW-1:0] c);
        logic [CW-1:0] r;
        if (c > ICW'(NE)) begin
            r = CW'(NE);
        end else begin
            r = c[CW-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/hhdt_cell.sv -----
// One table slot of the rotating entry ring.
`default_nettype none
module hhdt_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire hhdt_pkg::ring_ctl_t ctl,
    input  wire hhdt_pkg::entry_t    din,
    output hhdt_pkg::entry_t         dout
);
    import hhdt_pkg::*;

    logic            vld_reg;
    logic [KW-1:0]   key_reg;
    logic [CNTW-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr) begin
            vld_reg <= 1'b0;
        end else if (ctl.shift) begin
            vld_reg <= din.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            key_reg <= din.key;
            cnt_reg <= din.cnt;
        end
    end

    assign dout.vld = vld_reg;
    assign dout.key = key_reg;
    assign dout.cnt = cnt_reg;

endmodule
`default_nettype wire

// ----- hdl/hhdt_ctrl.sv -----
// Sequencer, head-of-ring update logic, capacity divider and output register.
`default_nettype none
module hhdt_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire hhdt_pkg::in_t          s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output hhdt_pkg::out_t              m_data,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [hhdt_pkg::CFGW-1:0] cfg_data,
    input  wire hhdt_pkg::entry_t       head,
    output hhdt_pkg::entry_t            head_nx,
    output hhdt_pkg::ring_ctl_t         ring_ctl
);
    import hhdt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_DCHK, S_DIV, S_GROW, S_PASS2, S_EMIT, S_RPT, S_RFL, S_CLRO
    } state_t;

    state_t          state_reg;
    logic            mode_reg;
    logic [PW-1:0]   period_reg;
    logic [ICW-1:0]  icap_reg;

    logic [1:0]      func_reg;
    logic [KW-1:0]   key_reg;
    logic [AW-1:0]   amt_reg;
    logic [CNTW-1:0] thr_reg;

    logic [CNTW-1:0] dec_reg;
    logic [CNTW-1:0] tot_reg;
    logic [CW-1:0]   cap_reg;
    logic [CNTW-1:0] peak_reg;
    logic            satf_reg;

    logic [IW-1:0]   idx_reg;
    logic            found_reg;
    logic [CW-1:0]   used_reg;
    logic [IW-1:0]   free_reg;
    logic            free_ok_reg;
    logic [CNTW-1:0] min_reg;
    logic            res_hit_reg;
    logic [CNTW-1:0] res_low_reg;
    logic            ins_mode_reg;
    logic            ins_done_reg;

    logic [CNTW-1:0] rem_reg;
    logic [PW+4:0]   dsr_reg;
    logic [QB:0]     q_reg;
    logic [2:0]      dcnt_reg;

    logic            pend_vld_reg;
    out_t            pend_reg;
    logic            m_valid_reg;
    out_t            m_data_reg;

    logic            accept;
    logic            out_free;
    logic            load_out;
    logic [CNTW-1:0] amt48;
    logic            hit_key;
    logic            found_now;
    logic [CW-1:0]   used_now;
    logic [CNTW-1:0] cnt_plus;
    logic [CNTW-1:0] dec_cnt;
    logic            dec_vld;
    logic            dec_ins;
    logic            rpt_hit;
    logic [CNTW-1:0] head_est;
    logic            step;
    logic [PW-1:0]   per;
    logic [15:0]     tgt_raw;
    logic            tgt_sat;
    logic [CW-1:0]   tgt;
    logic [CNTW-1:0] res_high;
    logic [CNTW-1:0] peak_nx;
    logic [KW-1:0]   key_in;
    out_t            rpt_item;
    out_t            zero_item;
    out_t            pend_last;
    logic            last_idx;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (((state_reg == S_EMIT) || (state_reg == S_RFL) ||
                        (state_reg == S_CLRO)) && out_free) ||
                      ((state_reg == S_RPT) && step && rpt_hit && pend_vld_reg);
    assign amt48    = {{(CNTW-AW){1'b0}}, amt_reg};
    assign per      = (period_reg == '0) ? PW'(1) : period_reg;
    assign last_idx = (idx_reg == IW'(NE-1));
    assign key_in   = mode_reg ? s_data.key : {32'b0, s_data.key[31:0]};

    always_comb begin
        hit_key   = head.vld && (head.key == key_reg);
        found_now = found_reg || hit_key;
        used_now  = used_reg + CW'(head.vld);
        cnt_plus  = sat_add(head.cnt, amt48);
        dec_cnt   = head.cnt - min_reg;
        dec_vld   = head.vld && (dec_cnt != '0);
        dec_ins   = !dec_vld && !ins_done_reg && (min_reg < amt48);
        head_est  = sat_add(head.cnt, dec_reg);
        rpt_hit   = head.vld && (head_est >= thr_reg);
        res_high  = sat_add(res_low_reg, dec_reg);
        peak_nx   = peak_reg;
        if (res_hit_reg) begin
            if (res_high > peak_reg) peak_nx = res_high;
        end else begin
            if (dec_reg > peak_reg) peak_nx = dec_reg;
        end
        if (q_reg >= (QB+1)'(NE)) begin
            tgt_raw = 16'(NE + 1);
        end else begin
            tgt_raw = (16'(q_reg) + 16'd1) * (16'(q_reg) + 16'd2) - 16'd1;
        end
        tgt_sat = (tgt_raw > 16'(NE));
        tgt     = tgt_sat ? CW'(NE) : tgt_raw[CW-1:0];

        rpt_item.key_out            = head.key;
        rpt_item.hit                = 1'b1;
        rpt_item.low_estimate       = head.cnt;
        rpt_item.high_estimate      = head_est;
        rpt_item.peak_estimate      = peak_reg;
        rpt_item.capacity_saturated = satf_reg;
        rpt_item.last_item          = 1'b0;
        zero_item = '0;
        zero_item.last_item = 1'b1;
        pend_last = pend_reg;
        pend_last.last_item = 1'b1;

        head_nx = head;
        step    = 1'b0;
        unique case (state_reg)
            S_LOOK: begin
                step = 1'b1;
                if (hit_key && (func_reg == FN_UPDATE)) head_nx.cnt = cnt_plus;
            end
            S_PASS2: begin
                step = 1'b1;
                if (ins_mode_reg) begin
                    if (idx_reg == free_reg) begin
                        head_nx.vld = 1'b1;
                        head_nx.key = key_reg;
                        head_nx.cnt = amt48;
                    end
                end else if (dec_ins) begin
                    head_nx.vld = 1'b1;
                    head_nx.key = key_reg;
                    head_nx.cnt = amt48 - min_reg;
                end else begin
                    head_nx.vld = dec_vld;
                    head_nx.cnt = dec_cnt;
                end
            end
            S_RPT: begin
                step = !rpt_hit || !pend_vld_reg || out_free;
            end
            default: begin
                step = 1'b0;
            end
        endcase
        ring_ctl.shift = step;
        ring_ctl.clr   = accept && (s_data.func == FN_CLEAR);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mode_reg     <= 1'b1;
            period_reg   <= PERIOD_RST;
            icap_reg     <= ICAP_RST;
            dec_reg      <= '0;
            tot_reg      <= '0;
            cap_reg      <= cap_lim(ICAP_RST);
            peak_reg     <= '0;
            satf_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_ready && !load_out) m_valid_reg <= 1'b0;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MODE:   mode_reg   <= cfg_data[0];
                    CFG_PERIOD: period_reg <= cfg_data[PW-1:0];
                    CFG_ICAP:   icap_reg   <= cfg_data[ICW-1:0];
                    default:    ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        func_reg     <= s_data.func;
                        key_reg      <= key_in;
                        amt_reg      <= s_data.amount;
                        thr_reg      <= s_data.threshold;
                        idx_reg      <= '0;
                        found_reg    <= 1'b0;
                        used_reg     <= '0;
                        free_ok_reg  <= 1'b0;
                        free_reg     <= '0;
                        min_reg      <= {{(CNTW-AW){1'b0}}, s_data.amount};
                        res_hit_reg  <= 1'b0;
                        res_low_reg  <= '0;
                        ins_done_reg <= 1'b0;
                        pend_vld_reg <= 1'b0;
                        unique case (s_data.func)
                            FN_UPDATE: begin
                                tot_reg   <= sat_add(tot_reg,
                                                     {{(CNTW-AW){1'b0}}, s_data.amount});
                                state_reg <= S_LOOK;
                            end
                            FN_QUERY:  state_reg <= S_LOOK;
                            FN_REPORT: state_reg <= S_RPT;
                            FN_CLEAR: begin
                                dec_reg   <= '0;
                                tot_reg   <= '0;
                                peak_reg  <= '0;
                                satf_reg  <= 1'b0;
                                cap_reg   <= cap_lim(icap_reg);
                                state_reg <= S_CLRO;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_LOOK: begin
                    idx_reg  <= idx_reg + IW'(1);
                    used_reg <= used_now;
                    if (hit_key && !found_reg) begin
                        found_reg   <= 1'b1;
                        res_low_reg <= (func_reg == FN_UPDATE) ? cnt_plus : head.cnt;
                    end
                    if (!head.vld && !free_ok_reg) begin
                        free_ok_reg <= 1'b1;
                        free_reg    <= idx_reg;
                    end
                    if (head.vld && (head.cnt < min_reg)) min_reg <= head.cnt;
                    if (last_idx) begin
                        res_hit_reg <= found_now;
                        if ((func_reg != FN_UPDATE) || found_now) begin
                            state_reg <= S_EMIT;
                        end else if (used_now < cap_reg) begin
                            ins_mode_reg <= 1'b1;
                            state_reg    <= S_PASS2;
                        end else begin
                            state_reg <= S_DCHK;
                        end
                    end
                end
                S_DCHK: begin
                    if (tot_reg >= {1'b0, per, {QB{1'b0}}}) begin
                        q_reg     <= (QB+1)'(1 << QB);
                        state_reg <= S_GROW;
                    end else begin
                        rem_reg   <= tot_reg;
                        dsr_reg   <= {per, {(QB-1){1'b0}}};
                        q_reg     <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem_reg >= CNTW'(dsr_reg)) begin
                        rem_reg <= rem_reg - CNTW'(dsr_reg);
                        q_reg   <= {q_reg[QB-1:0], 1'b1};
                    end else begin
                        q_reg   <= {q_reg[QB-1:0], 1'b0};
                    end
                    dsr_reg  <= dsr_reg >> 1;
                    dcnt_reg <= dcnt_reg + 3'd1;
                    if (dcnt_reg == 3'(QB-1)) state_reg <= S_GROW;
                end
                S_GROW: begin
                    if (tgt_sat) satf_reg <= 1'b1;
                    if (cap_reg < tgt) begin
                        cap_reg      <= tgt;
                        ins_mode_reg <= 1'b1;
                    end else begin
                        ins_mode_reg <= 1'b0;
                        dec_reg      <= sat_add(dec_reg, min_reg);
                    end
                    state_reg <= S_PASS2;
                end
                S_PASS2: begin
                    idx_reg <= idx_reg + IW'(1);
                    if (ins_mode_reg) begin
                        if (idx_reg == free_reg) begin
                            res_hit_reg <= 1'b1;
                            res_low_reg <= amt48;
                        end
                    end else if (dec_ins) begin
                        ins_done_reg <= 1'b1;
                        res_hit_reg  <= 1'b1;
                        res_low_reg  <= amt48 - min_reg;
                    end
                    if (last_idx) state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg                   <= 1'b1;
                        m_data_reg.key_out            <= key_reg;
                        m_data_reg.hit                <= res_hit_reg;
                        m_data_reg.low_estimate       <= res_low_reg;
                        m_data_reg.high_estimate      <= res_high;
                        m_data_reg.capacity_saturated <= satf_reg;
                        m_data_reg.last_item          <= 1'b1;
                        if (func_reg == FN_UPDATE) begin
                            peak_reg                 <= peak_nx;
                            m_data_reg.peak_estimate <= peak_nx;
                        end else begin
                            m_data_reg.peak_estimate <= peak_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_RPT: begin
                    if (step) begin
                        idx_reg <= idx_reg + IW'(1);
                        if (rpt_hit) begin
                            if (pend_vld_reg) begin
                                m_valid_reg <= 1'b1;
                                m_data_reg  <= pend_reg;
                            end
                            pend_vld_reg <= 1'b1;
                            pend_reg     <= rpt_item;
                        end
                        if (last_idx) state_reg <= S_RFL;
                    end
                end
                S_RFL: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (pend_vld_reg) begin
                            m_data_reg <= pend_last;
                        end else begin
                            m_data_reg <= zero_item;
                        end
                        pend_vld_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                S_CLRO: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= zero_item;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_cap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_reg <= CW'(NE))
        else $error("capacity beyond table size");

    a_total_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.func == FN_UPDATE)) |=> (tot_reg >= $past(tot_reg)))
        else $error("running total decreased on update");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < {1'b0, dsr_reg, 1'b0}))
        else $error("divider remainder out of range");
`endif

endmodule
`default_nettype wire

// ----- hdl/heavy_hitter_dynamic_table.sv -----
// Top level: rotating ring of table cells with its sequencer.
// Query: one lookup pass around the ring, then the result register.
// Update: lookup pass and result register on a hit; on a miss, lookup pass, up to
// 6 divider steps for the growth target, then an insert or decrement pass.
// Report: a ring pass, held by output stalls. One transaction at a time.
// Reset (aresetn low, synchronous) empties the table at once; no clearing pass.
`default_nettype none
module heavy_hitter_dynamic_table (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire hhdt_pkg::in_t           s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output hhdt_pkg::out_t               m_data,
    input  wire logic                    cfg_we,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [hhdt_pkg::CFGW-1:0] cfg_data
);
    import hhdt_pkg::*;

    entry_t    cell_q [NE];
    entry_t    head_nx;
    ring_ctl_t ring_ctl;

    hhdt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (cell_q[0]),
        .head_nx   (head_nx),
        .ring_ctl  (ring_ctl)
    );

    for (genvar i = 0; i < NE; i++) begin : g_cell
        if (i == NE - 1) begin : g_tail
            hhdt_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ring_ctl),
                .din     (head_nx),
                .dout    (cell_q[i])
            );
        end else begin : g_mid
            hhdt_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ring_ctl),
                .din     (cell_q[i+1]),
                .dout    (cell_q[i])
            );
        end
    end

endmodule
`default_nettype wire
